### src/rbsi_pkg.sv
`timescale 1ns / 1ps

package rbsi_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DW         = 32;
  localparam int DVD_W      = DW + FRAC_BITS;
  localparam int QUO_W      = DW - 1;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = DW / DIV_STEP;
  localparam int PIPE_DEPTH = 2 * DIV_STAGES + 8;
  localparam int EPS_W      = FRAC_BITS + 1;
  localparam int UV_W       = FRAC_BITS + 1;
  localparam int SUM_W      = 2 * DW - FRAC_BITS + 1;
  localparam int IN_W       = 6 * DW;
  localparam int OUT_USED   = 1 + (DW - 1) + 3 * DW + 2 + 1 + 2 * UV_W + 2;
  localparam int OUT_W      = ((OUT_USED + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int EPS_RESET  = 7;

  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0]        ONE_Q = DW'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X, REG_MIN_Y, REG_MIN_Z, REG_MAX_X, REG_MAX_Y, REG_MAX_Z, REG_EPSILON
  } cfg_reg_t;

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

  // ray data riding along the slab dividers
  typedef struct packed {
    logic [2:0][DW-1:0] o;
    logic [2:0][DW-1:0] d;
    logic [2:0]         bnd;
    logic               umiss;
    logic [2:0]         neg_lo;
    logic [2:0]         neg_hi;
  } ray_sb_t;

  typedef struct packed {
    logic            hit;
    logic [DW-2:0]   hit_dist;
    axis_t           axis;
    logic            neg;
  } hit_info_t;

  // hit data riding along the face dividers
  typedef struct packed {
    hit_info_t          res;
    logic [2:0][DW-1:0] p;
    axis_t              tan;
    logic               u_ok;
    logic               v_ok;
  } face_sb_t;

endpackage

### src/rbsi_div.sv
`timescale 1ns / 1ps

module rbsi_div import rbsi_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DW-1:0]    dvs,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  logic [DW-1:0] rem_r [DIV_STAGES-1];
  logic [DW-1:0] dvs_r [DIV_STAGES-1];
  logic [DW-1:0] dq_r  [DIV_STAGES];
  logic          ovf_r [DIV_STAGES];

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic logic [2*DW-1:0] div_step(input logic [DW-1:0] rem,
                                               input logic [DW-1:0] dq,
                                               input logic [DW-1:0] d);
    logic [DW:0] sh;
    logic [DW:0] df;
    sh = {rem, dq[DW-1]};
    df = sh - {1'b0, d};
    if (df[DW]) begin
      return {sh[DW-1:0], dq[DW-2:0], 1'b0};
    end
    return {df[DW-1:0], dq[DW-2:0], 1'b1};
  endfunction

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    logic [DW-1:0] rem_i;
    logic [DW-1:0] dq_i;
    logic [DW-1:0] dvs_i;
    logic          ovf_i;
    logic [DW-1:0] rem_o;
    logic [DW-1:0] dq_o;

    if (s == 0) begin : g_head
      assign rem_i = DW'(dvd[DVD_W-1:DW]);
      assign dq_i  = dvd[DW-1:0];
      assign dvs_i = dvs;
      // quotient would need more than DW bits
      assign ovf_i = DW'(dvd[DVD_W-1:DW]) >= dvs;
    end else begin : g_body
      assign rem_i = rem_r[s-1];
      assign dq_i  = dq_r[s-1];
      assign dvs_i = dvs_r[s-1];
      assign ovf_i = ovf_r[s-1];
    end

    always_comb begin : p_steps
      logic [2*DW-1:0] acc;
      acc = {rem_i, dq_i};
      for (int j = 0; j < DIV_STEP; j++) begin
        acc = div_step(acc[2*DW-1:DW], acc[DW-1:0], dvs_i);
      end
      rem_o = acc[2*DW-1:DW];
      dq_o  = acc[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[s]  <= dq_o;
        ovf_r[s] <= ovf_i;
      end
    end

    if (s < DIV_STAGES - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_o;
          dvs_r[s] <= dvs_i;
        end
      end
    end
  end

  assign quo = dq_r[DIV_STAGES-1][QUO_W-1:0];
  assign ovf = ovf_r[DIV_STAGES-1] | dq_r[DIV_STAGES-1][DW-1];

endmodule

### src/ray_box_slab_intersect_unit.sv
`timescale 1ns / 1ps
// channel | dir | beat contents
// in_     | in  | tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
// out_    | out | tdata: hit, hit_distance, point_x/y/z, normal_axis, normal_negative,
//         |     |        face_u, face_v, tangent_axis
// cfg_    | in  | cfg_index selects the register, cfg_data carries the value
//
// one ray enters per cycle while no output beat waits; two banks of 16-stage
// pipelined dividers (two quotient bits per stage) give the slab distances and face uv
// reset clears all valid bits and loads the unit box and epsilon of 7
// a waiting output beat holds the whole pipeline; in_tready is low only then
// cfg_ready is always high

module ray_box_slab_intersect_unit import rbsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [IN_W-1:0]      in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // hit, hit_distance, point_x, point_y, point_z, normal_axis, normal_negative,
  // face_u, face_v, tangent_axis, zero pad
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]        cfg_data
);

  logic signed [DW-1:0] box_lo_r [3];
  logic signed [DW-1:0] box_hi_r [3];
  logic [EPS_W-1:0]     eps_r;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_r;

  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        box_lo_r[k] <= '0;
        box_hi_r[k] <= ONE_Q;
      end
      eps_r <= EPS_W'(EPS_RESET);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_X:   box_lo_r[0] <= cfg_data;
        REG_MIN_Y:   box_lo_r[1] <= cfg_data;
        REG_MIN_Z:   box_lo_r[2] <= cfg_data;
        REG_MAX_X:   box_hi_r[0] <= cfg_data;
        REG_MAX_Y:   box_hi_r[1] <= cfg_data;
        REG_MAX_Z:   box_hi_r[2] <= cfg_data;
        REG_EPSILON: eps_r       <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  // ---- stage a: slab offsets as magnitude and quotient sign
  logic signed [DW-1:0] o_a [3];
  logic signed [DW-1:0] d_a [3];
  logic [2:0]           lo_ge;
  logic [2:0]           hi_ge;
  logic [DW-1:0]        adl_nxt [3];
  logic [DW-1:0]        adh_nxt [3];
  logic [DW-1:0]        ad_nxt  [3];
  ray_sb_t              sb_a_nxt;
  logic [DW-1:0]        adl_r [3];
  logic [DW-1:0]        adh_r [3];
  logic [DW-1:0]        ad_r  [3];
  ray_sb_t              sb_a_r;

  always_comb begin
    sb_a_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      o_a[k]   = signed'(in_tdata[DW*k +: DW]);
      d_a[k]   = signed'(in_tdata[DW*(k+3) +: DW]);
      lo_ge[k] = box_lo_r[k] >= o_a[k];
      hi_ge[k] = box_hi_r[k] >= o_a[k];
      // magnitude fits DW bits unsigned, so wrapping subtraction is exact
      adl_nxt[k] = lo_ge[k] ? box_lo_r[k] - o_a[k] : o_a[k] - box_lo_r[k];
      adh_nxt[k] = hi_ge[k] ? box_hi_r[k] - o_a[k] : o_a[k] - box_hi_r[k];
      ad_nxt[k]  = d_a[k][DW-1] ? -d_a[k] : d_a[k];
      sb_a_nxt.o[k]      = o_a[k];
      sb_a_nxt.d[k]      = d_a[k];
      sb_a_nxt.bnd[k]    = |d_a[k];
      sb_a_nxt.neg_lo[k] = !lo_ge[k] ^ d_a[k][DW-1];
      sb_a_nxt.neg_hi[k] = !hi_ge[k] ^ d_a[k][DW-1];
      // parallel ray outside its slab never hits
      if (!sb_a_nxt.bnd[k] && (!lo_ge[k] ? 1'b0 : (box_lo_r[k] != o_a[k]))) begin
        sb_a_nxt.umiss = 1'b1;
      end
      if (!sb_a_nxt.bnd[k] && !hi_ge[k]) begin
        sb_a_nxt.umiss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adl_r  <= adl_nxt;
      adh_r  <= adh_nxt;
      ad_r   <= ad_nxt;
      sb_a_r <= sb_a_nxt;
    end
  end

  // ---- slab dividers
  logic [QUO_W-1:0] ql [3];
  logic [QUO_W-1:0] qh [3];
  logic             ovl [3];
  logic             ovh [3];
  ray_sb_t          sb1_r [DIV_STAGES];

  for (genvar k = 0; k < 3; k++) begin : g_slab
    rbsi_div u_div_lo (
      .clk (clk),
      .en  (en),
      .dvd ({adl_r[k], {FRAC_BITS{1'b0}}}),
      .dvs (ad_r[k]),
      .quo (ql[k]),
      .ovf (ovl[k])
    );
    rbsi_div u_div_hi (
      .clk (clk),
      .en  (en),
      .dvd ({adh_r[k], {FRAC_BITS{1'b0}}}),
      .dvs (ad_r[k]),
      .quo (qh[k]),
      .ovf (ovh[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r[0] <= sb_a_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        sb1_r[i] <= sb1_r[i-1];
      end
    end
  end

  // ---- stage c: signed, saturated, ordered slab distances
  function automatic logic signed [DW-1:0] slab_t(input logic [QUO_W-1:0] q,
                                                  input logic ovf, input logic neg);
    if (ovf) begin
      return neg ? S_MIN : S_MAX;
    end
    return neg ? -signed'({1'b0, q}) : signed'({1'b0, q});
  endfunction

  ray_sb_t              sb_c_in;
  logic signed [DW-1:0] tl [3];
  logic signed [DW-1:0] th [3];
  logic signed [DW-1:0] t0_c_nxt [3];
  logic signed [DW-1:0] t1_c_nxt [3];
  logic signed [DW-1:0] t0_c_r [3];
  logic signed [DW-1:0] t1_c_r [3];
  ray_sb_t              sb_c_r;

  assign sb_c_in = sb1_r[DIV_STAGES-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tl[k] = slab_t(ql[k], ovl[k], sb_c_in.neg_lo[k]);
      th[k] = slab_t(qh[k], ovh[k], sb_c_in.neg_hi[k]);
      if (tl[k] > th[k]) begin
        t0_c_nxt[k] = th[k];
        t1_c_nxt[k] = tl[k];
      end else begin
        t0_c_nxt[k] = tl[k];
        t1_c_nxt[k] = th[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_c_r <= t0_c_nxt;
      t1_c_r <= t1_c_nxt;
      sb_c_r <= sb_c_in;
    end
  end

  // ---- stage d: entry is the latest slab entry, exit the earliest slab exit
  logic signed [DW-1:0] t0m [3];
  logic signed [DW-1:0] t1m [3];
  logic signed [DW-1:0] ten_a;
  logic signed [DW-1:0] tex_a;
  logic signed [DW-1:0] ten_nxt;
  logic signed [DW-1:0] tex_nxt;
  logic signed [DW-1:0] ten_r;
  logic signed [DW-1:0] tex_r;
  logic signed [DW-1:0] t0_d_r [3];
  logic signed [DW-1:0] t1_d_r [3];
  logic                 miss_d_r;
  ray_sb_t              sb_d_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // unbounded slabs take the neutral value
      t0m[k] = sb_c_r.bnd[k] ? t0_c_r[k] : S_MIN;
      t1m[k] = sb_c_r.bnd[k] ? t1_c_r[k] : S_MAX;
    end
    ten_a   = (t0m[0] > t0m[1]) ? t0m[0] : t0m[1];
    ten_nxt = (ten_a > t0m[2]) ? ten_a : t0m[2];
    tex_a   = (t1m[0] < t1m[1]) ? t1m[0] : t1m[1];
    tex_nxt = (tex_a < t1m[2]) ? tex_a : t1m[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ten_r    <= ten_nxt;
      tex_r    <= tex_nxt;
      t0_d_r   <= t0_c_r;
      t1_d_r   <= t1_c_r;
      miss_d_r <= sb_c_r.umiss || !(|sb_c_r.bnd);
      sb_d_r   <= sb_c_r;
    end
  end

  // ---- stage e: hit decision, distance and face normal
  logic signed [DW-1:0] eps_s;
  logic                 entering;
  logic signed [DW-1:0] thit;
  hit_info_t            res_e_nxt;
  hit_info_t            res_e_r;
  ray_sb_t              sb_e_r;

  always_comb begin
    eps_s    = signed'(DW'(eps_r));
    entering = ten_r >= eps_s;
    thit     = entering ? ten_r : tex_r;
    res_e_nxt.hit      = !(miss_d_r || (ten_r > tex_r) || (tex_r < eps_s));
    res_e_nxt.hit_dist = thit[DW-2:0];
    res_e_nxt.axis     = AXIS_X;
    res_e_nxt.neg      = 1'b0;
    // first matching axis in x, y, z order wins
    for (int a = 2; a >= 0; a--) begin
      if (sb_d_r.bnd[a] && (entering ? t0_d_r[a] == thit : t1_d_r[a] == thit)) begin
        res_e_nxt.axis = axis_t'(2'(a));
        res_e_nxt.neg  = entering ? (signed'(sb_d_r.d[a]) > 0) : sb_d_r.d[a][DW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_e_r <= res_e_nxt;
      sb_e_r  <= sb_d_r;
    end
  end

  // ---- stage f: direction times distance
  logic signed [2*DW-1:0] prod_nxt [3];
  logic signed [2*DW-1:0] prod_r [3];
  logic signed [DW-1:0]   o_f_r [3];
  hit_info_t              res_f_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = signed'(sb_e_r.d[k]) * signed'({1'b0, res_e_r.hit_dist});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      res_f_r <= res_e_r;
      for (int k = 0; k < 3; k++) begin
        o_f_r[k] <= sb_e_r.o[k];
      end
    end
  end

  // ---- stage g: hit point, floored product, saturated
  logic signed [SUM_W-1:0] psum [3];
  logic signed [DW-1:0]    p_nxt [3];
  logic signed [DW-1:0]    p_r [3];
  hit_info_t               res_g_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psum[k] = SUM_W'(o_f_r[k]) + SUM_W'(prod_r[k] >>> FRAC_BITS);
      if (psum[k] > SUM_W'(S_MAX)) begin
        p_nxt[k] = S_MAX;
      end else if (psum[k] < SUM_W'(S_MIN)) begin
        p_nxt[k] = S_MIN;
      end else begin
        p_nxt[k] = psum[k][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_nxt;
      res_g_r <= res_f_r;
    end
  end

  // ---- stage h: face offsets and extents
  logic signed [DW:0] du;
  logic signed [DW:0] dv;
  logic signed [DW:0] su;
  logic signed [DW:0] sv;
  logic [1:0]         ua;
  logic [1:0]         va;
  face_sb_t           sb_h_nxt;
  face_sb_t           sb_h_r;
  logic [DW-1:0]      du_r;
  logic [DW-1:0]      dv_r;
  logic [DW-1:0]      su_r;
  logic [DW-1:0]      sv_r;

  always_comb begin
    ua = (res_g_r.axis == AXIS_X) ? 2'd2 : 2'd0;
    va = (res_g_r.axis == AXIS_Y) ? 2'd2 : 2'd1;
    du = (DW+1)'(p_r[ua]) - (DW+1)'(box_lo_r[ua]);
    dv = (DW+1)'(p_r[va]) - (DW+1)'(box_lo_r[va]);
    su = (DW+1)'(box_hi_r[ua]) - (DW+1)'(box_lo_r[ua]);
    sv = (DW+1)'(box_hi_r[va]) - (DW+1)'(box_lo_r[va]);
    sb_h_nxt.res  = res_g_r;
    for (int k = 0; k < 3; k++) begin
      sb_h_nxt.p[k] = p_r[k];
    end
    sb_h_nxt.tan  = (res_g_r.axis == AXIS_Y) ? AXIS_Z : AXIS_X;
    // a point behind the lower face or an empty extent gives zero
    sb_h_nxt.u_ok = !du[DW] && !su[DW] && (su != '0);
    sb_h_nxt.v_ok = !dv[DW] && !sv[DW] && (sv != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_h_r <= sb_h_nxt;
      du_r   <= du[DW-1:0];
      dv_r   <= dv[DW-1:0];
      su_r   <= su[DW-1:0];
      sv_r   <= sv[DW-1:0];
    end
  end

  // ---- face dividers
  logic [QUO_W-1:0] qu;
  logic [QUO_W-1:0] qv;
  logic             ovu;
  logic             ovv;
  face_sb_t         sb2_r [DIV_STAGES];

  rbsi_div u_div_u (
    .clk (clk),
    .en  (en),
    .dvd ({du_r, {FRAC_BITS{1'b0}}}),
    .dvs (su_r),
    .quo (qu),
    .ovf (ovu)
  );

  rbsi_div u_div_v (
    .clk (clk),
    .en  (en),
    .dvd ({dv_r, {FRAC_BITS{1'b0}}}),
    .dvs (sv_r),
    .quo (qv),
    .ovf (ovv)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r[0] <= sb_h_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        sb2_r[i] <= sb2_r[i-1];
      end
    end
  end

  // ---- output register
  function automatic logic [UV_W-1:0] uv_clamp(input logic [QUO_W-1:0] q,
                                               input logic ovf, input logic ok);
    if (!ok) begin
      return '0;
    end
    if (ovf || (q > ONE_Q[QUO_W-1:0])) begin
      return ONE_Q[UV_W-1:0];
    end
    return q[UV_W-1:0];
  endfunction

  face_sb_t         sb_o;
  logic [OUT_W-1:0] out_nxt;
  logic [OUT_W-1:0] out_r;

  assign sb_o = sb2_r[DIV_STAGES-1];

  always_comb begin
    out_nxt = '0;
    if (sb_o.res.hit) begin
      out_nxt = {{(OUT_W-OUT_USED){1'b0}}, sb_o.tan, uv_clamp(qv, ovv, sb_o.v_ok),
                 uv_clamp(qu, ovu, sb_o.u_ok), sb_o.res.neg, sb_o.res.axis,
                 sb_o.p[2], sb_o.p[1], sb_o.p[0], sb_o.res.hit_dist, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_tdata = out_r;

  // ---- checks
  localparam int UO = 3 * DW + DW + 3;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata == '0)
    else $error("miss beat carries nonzero fields");

  a_tangent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      (out_tdata[4*DW+1:4*DW] != 2'd3) &&
      ((out_tdata[4*DW+1:4*DW] == AXIS_Y) ?
        (out_tdata[UO+2*UV_W+1:UO+2*UV_W] == AXIS_Z) :
        (out_tdata[UO+2*UV_W+1:UO+2*UV_W] == AXIS_X)))
    else $error("normal and tangent axes disagree");

  a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[UO+UV_W-1:UO] <= ONE_Q[UV_W-1:0]) &&
                   (out_tdata[UO+2*UV_W-1:UO+UV_W] <= ONE_Q[UV_W-1:0]))
    else $error("face coordinate above one");

  a_hit_eps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[DW-1:1] >= (DW-1)'(eps_r))
    else $error("hit distance below epsilon");

endmodule
